// File: hw/rtl/pie_pkg.sv
// Package for the prefix instruction encoder: payload structs, the queued job
// record, register indexes and reset values. No dependencies.
package pie_pkg;

    // Fixed field widths
    localparam int FUNC_W        = 8;
    localparam int OPERAND_BITS  = 32;
    localparam int SLOT_W        = 5;
    localparam int BYTE_W        = 8;
    localparam int WORD_MAX_BITS = 64;
    localparam int JOB_LEN_W     = 5;
    localparam int CFG_INDEX_W   = 1;
    localparam int QUEUE_DEPTH   = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEG_PREFIX = 1'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0] PREFIX_RESET     = 8'h20;
    localparam logic [BYTE_W-1:0] NEG_PREFIX_RESET = 8'h60;

    // One instruction to encode
    typedef struct packed {
        logic [FUNC_W-1:0]              function_code;
        logic signed [OPERAND_BITS-1:0] operand;
        logic [SLOT_W-1:0]              slot_bytes;
    } cmd_t;

    // One emitted byte or the error marker
    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              final_byte;
        logic              overflow_error;
    } result_t;

    // Classified job handed from front to back. word holds the target word,
    // complemented when negative, zero-extended.
    typedef struct packed {
        logic [FUNC_W-1:0]        function_code;
        logic [WORD_MAX_BITS-1:0] word;
        logic                     negative;
        logic [JOB_LEN_W-1:0]     length;
        logic [SLOT_W-1:0]        slot;
        logic                     overflow;
    } job_t;

endpackage

// File: hw/rtl/pie_front.sv
// Front end: classifies one instruction into a job (sign, encoded length,
// fit check). Depends on pie_pkg.
module pie_front #(
    parameter int WORD_BITS = 32,
    parameter int MAX_SLOT  = 16
) (
    input  pie_pkg::cmd_t cmd,
    output pie_pkg::job_t job
);

    localparam int NIB = (WORD_BITS + 3) / 4;

    logic [pie_pkg::WORD_MAX_BITS-1:0] op_sx;
    logic [WORD_BITS-1:0]              word;
    logic                              negative;
    logic [WORD_BITS-1:0]              mag;
    logic [NIB*4-1:0]                  mag_ext;
    logic [pie_pkg::JOB_LEN_W-1:0]     top;
    logic [pie_pkg::JOB_LEN_W-1:0]     length;
    logic                              overflow;

    // Target word: sign-extend, then keep WORD_BITS bits
    assign op_sx    = {{(pie_pkg::WORD_MAX_BITS - pie_pkg::OPERAND_BITS){cmd.operand[31]}},
                       cmd.operand};
    assign word     = op_sx[WORD_BITS-1:0];
    assign negative = word[WORD_BITS-1];
    assign mag      = negative ? ~word : word;
    assign mag_ext  = (NIB*4)'(mag);

    // Highest nonzero nibble of the (complemented) word
    always_comb
    begin
        top = '0;
        for (int i = 0; i < NIB; i++)
        begin
            if (mag_ext[4*i +: 4] != 4'd0)
            begin
                top = pie_pkg::JOB_LEN_W'(i);
            end
        end
    end

    // A negative word always takes at least the final byte and one negative prefix
    assign length = (negative && top == '0) ? pie_pkg::JOB_LEN_W'(2) : top + 1'b1;

    assign overflow = (cmd.slot_bytes == '0) || (int'(cmd.slot_bytes) > MAX_SLOT) ||
                      (int'(length) > int'(cmd.slot_bytes));

    assign job.function_code = cmd.function_code;
    assign job.word          = pie_pkg::WORD_MAX_BITS'(mag_ext);
    assign job.negative      = negative;
    assign job.length        = length;
    assign job.slot          = cmd.slot_bytes;
    assign job.overflow      = overflow;

endmodule

// File: hw/rtl/pie_queue.sv
// Short job queue between front and back, so each side stalls on its own.
// Depends on pie_pkg.
module pie_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  pie_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output pie_pkg::job_t rd_data,
    output logic          empty
);

    localparam int DEPTH = pie_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pie_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // A write without a read grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on write");

endmodule

// File: hw/rtl/pie_back.sv
// Back end: walks one job a byte per cycle while the result slot is free or being
// popped, from the first memory byte to the last, into a result register. Depends on pie_pkg.
module pie_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pie_pkg::job_t                job,
    input  logic                         job_valid,
    output logic                         job_done,
    input  logic [pie_pkg::BYTE_W-1:0]   prefix_code,
    input  logic [pie_pkg::BYTE_W-1:0]   negative_prefix_code,
    output pie_pkg::result_t             result,
    output logic                         empty,
    input  logic                         pop
);

    localparam int NIB = (WORD_BITS + 3) / 4;

    logic [pie_pkg::SLOT_W-1:0] k_reg, k_next;
    logic                       out_valid_reg, out_valid_next;
    pie_pkg::result_t           result_reg, result_next;
    logic                       advance;
    logic [pie_pkg::SLOT_W-1:0] idx;
    logic [3:0]                 nib;
    logic [3:0]                 word_nib;

    // Step when a job waits and the result slot is free or being drained
    assign advance = job_valid && (!out_valid_reg || pop);
    assign idx     = job.slot - 1'b1 - k_reg;

    // Nibble at the current byte position
    always_comb
    begin
        nib = 4'd0;
        for (int i = 0; i < NIB; i++)
        begin
            if (idx == pie_pkg::SLOT_W'(i))
            begin
                nib = job.word[4*i +: 4];
            end
        end
    end

    // Undo the complement for the plain nibbles of a negative word
    assign word_nib = nib ^ {4{job.negative}};

    // Byte selection and sequencing
    always_comb
    begin
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        job_done       = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (job.overflow)
            begin
                result_next.code_byte      = '0;
                result_next.final_byte     = 1'b0;
                result_next.overflow_error = 1'b1;
                job_done                   = 1'b1;
            end
            else
            begin
                result_next.overflow_error = 1'b0;
                result_next.final_byte     = (idx == '0);
                if (int'(idx) >= int'(job.length))
                begin
                    // padding ahead of the encoding
                    result_next.code_byte = prefix_code;
                end
                else if (idx == '0)
                begin
                    result_next.code_byte = job.function_code | {4'd0, word_nib};
                end
                else if (job.negative && int'(idx) == int'(job.length) - 1)
                begin
                    result_next.code_byte = negative_prefix_code | {4'd0, nib};
                end
                else
                begin
                    result_next.code_byte = prefix_code | {4'd0, word_nib};
                end
                job_done = (idx == '0);
            end
            k_next = job_done ? '0 : k_reg + 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign empty  = !out_valid_reg;

    // Byte counter stays inside the slot of a fitting job
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && !job.overflow) |-> k_reg < job.slot)
        else $error("byte counter ran past the slot");

    // Finishing a job rewinds the counter
    assert property (@(posedge clk) disable iff (!rst_n) job_done |=> k_reg == '0)
        else $error("byte counter not cleared after job");

    // An error result carries no byte and no end mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.overflow_error) |->
        (!result_reg.final_byte && result_reg.code_byte == '0))
        else $error("error result carries byte data");

endmodule

// File: hw/rtl/prefix_instruction_encoder_core.sv
// Prefix instruction encoder, top level: configuration registers, front end,
// job queue and back end. Depends on pie_pkg, pie_front, pie_queue, pie_back.
//
// Usage:
//   cmd channel: drive cmd and push; a transfer happens on a clock edge with
//   push high and full low. Each command names a function code, a signed
//   operand and a slot size in bytes.
//   result channel: while empty is low, result holds the oldest byte; pop
//   takes it. A fitting command yields slot_bytes results, first memory byte
//   first, final_byte set on the last. A command that does not fit, or has a
//   zero or oversized slot, yields one result with overflow_error set.
//   cfg port: cfg_we writes cfg_data to the register at cfg_index
//   (0 prefix code, 1 negative prefix code) on the same edge. Write only
//   while the block is idle.
// Timing: the first result of a command passes through the job queue and then
//   the result register. The back end sequencer emits one byte per cycle while
//   the result slot is free or popped; a 2-entry job queue lets new commands be
//   taken while earlier ones are still being emitted.
// Reset: registers return to 0x20 and 0x60, queue and result slot empty.
// Stall: with pop low the result holds and the sequencer pauses; push keeps
//   being taken until the job queue fills.
module prefix_instruction_encoder_core #(
    parameter int WORD_BITS = 32,
    parameter int MAX_SLOT  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pie_pkg::cmd_t                   cmd,
    input  logic                            push,
    output logic                            full,
    output pie_pkg::result_t                result,
    output logic                            empty,
    input  logic                            pop,
    input  logic                            cfg_we,
    input  logic [pie_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pie_pkg::BYTE_W-1:0]      cfg_data
);

    logic [pie_pkg::BYTE_W-1:0] prefix_code_reg, prefix_code_next;
    logic [pie_pkg::BYTE_W-1:0] neg_prefix_reg, neg_prefix_next;
    pie_pkg::job_t              front_job;
    pie_pkg::job_t              head_job;
    logic                       queue_empty;
    logic                       job_done;

    // Configuration register writes
    always_comb
    begin
        prefix_code_next = prefix_code_reg;
        neg_prefix_next  = neg_prefix_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pie_pkg::CFG_PREFIX:     prefix_code_next = cfg_data;
                pie_pkg::CFG_NEG_PREFIX: neg_prefix_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_code_reg <= pie_pkg::PREFIX_RESET;
            neg_prefix_reg  <= pie_pkg::NEG_PREFIX_RESET;
        end
        else
        begin
            prefix_code_reg <= prefix_code_next;
            neg_prefix_reg  <= neg_prefix_next;
        end
    end

    // Classify incoming commands
    pie_front #(
        .WORD_BITS (WORD_BITS),
        .MAX_SLOT  (MAX_SLOT)
    ) u_front (
        .cmd (cmd),
        .job (front_job)
    );

    // Jobs waiting for the back end
    pie_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_job),
        .full    (full),
        .rd_en   (job_done),
        .rd_data (head_job),
        .empty   (queue_empty)
    );

    // Emit bytes
    pie_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .job                  (head_job),
        .job_valid            (!queue_empty),
        .job_done             (job_done),
        .prefix_code          (prefix_code_reg),
        .negative_prefix_code (neg_prefix_reg),
        .result               (result),
        .empty                (empty),
        .pop                  (pop)
    );

endmodule

// File: tb/sv/testbench.sv
// Testbench for prefix_instruction_encoder_core: drives commands and register
// writes, predicts every emitted byte and checks the result channel.
// Depends on pie_pkg and the prefix_instruction_encoder_core RTL.
module testbench;

    localparam int WORD_SIZE      = 32;
    localparam int SLOT_LIMIT     = 16;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;

    logic                            clk;
    logic                            rst_n;
    pie_pkg::cmd_t                   cmd;
    logic                            push;
    logic                            full;
    pie_pkg::result_t                result;
    logic                            empty;
    logic                            pop;
    logic                            cfg_we;
    logic [pie_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pie_pkg::BYTE_W-1:0]      cfg_data;

    // Predictor state: register copies and the bytes still to arrive
    logic [7:0]       prefix_reg;
    logic [7:0]       neg_prefix_reg;
    logic [7:0]       enc_rev [0:19];
    pie_pkg::result_t expected_bytes [$];

    int  mismatch_count;
    int  idle_cycles;
    bit  tx_gaps;
    bit  rx_stalls;
    int  hold_request;

    prefix_instruction_encoder_core #(
        .WORD_BITS(WORD_SIZE),
        .MAX_SLOT (SLOT_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .push     (push),
        .full     (full),
        .result   (result),
        .empty    (empty),
        .pop      (pop),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Builds the encoding last byte first into enc_rev; returns its length
    function automatic int build_encoding_rev(input logic [7:0] fc, input logic [31:0] op);
        logic [31:0] w;
        int          n;
        n = 0;
        w = op;
        enc_rev[n] = fc | {4'h0, w[3:0]};
        n++;
        if (!w[31])
        begin
            w = w >> 4;
            while (w != 0)
            begin
                enc_rev[n] = prefix_reg | {4'h0, w[3:0]};
                n++;
                w = w >> 4;
            end
        end
        else
        begin
            // negative: complement, then prefixes carry the inverted nibbles
            w = (~w) >> 4;
            while (w >= 16)
            begin
                enc_rev[n] = prefix_reg | {4'h0, ~w[3:0]};
                n++;
                w = w >> 4;
            end
            enc_rev[n] = neg_prefix_reg | {4'h0, w[3:0]};
            n++;
        end
        return n;
    endfunction

    // Queues the bytes one command must produce
    task automatic predict_encoding(input pie_pkg::cmd_t c);
        int               n;
        int               slot;
        int               pad;
        pie_pkg::result_t r;
        n    = build_encoding_rev(c.function_code, c.operand);
        slot = c.slot_bytes;
        if (slot == 0 || slot > SLOT_LIMIT || n > slot)
        begin
            r.code_byte      = 8'h00;
            r.final_byte     = 1'b0;
            r.overflow_error = 1'b1;
            expected_bytes.push_back(r);
        end
        else
        begin
            // padding with plain prefix bytes, then the encoding first byte first
            pad = slot - n;
            for (int k = 0; k < slot; k++)
            begin
                r.code_byte      = (k < pad) ? prefix_reg : enc_rev[n - 1 - (k - pad)];
                r.final_byte     = (k == slot - 1);
                r.overflow_error = 1'b0;
                expected_bytes.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // One command transfer; push is left high for a following transfer
    task automatic send_cmd(input logic [7:0] fc, input logic [31:0] op, input logic [4:0] slot);
        int            gap;
        pie_pkg::cmd_t c;
        gap             = tx_gaps ? $urandom_range(0, 19) : 0;
        c.function_code = fc;
        c.operand       = op;
        c.slot_bytes    = slot;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd  <= c;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_encoding(c);
    endtask

    // Stop offering, wait for every expected byte, then let the pipe settle
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on consecutive edges; block must be idle
    task automatic set_registers(input logic [7:0] pfx, input logic [7:0] neg);
        cfg_we    <= 1'b1;
        cfg_index <= pie_pkg::CFG_PREFIX;
        cfg_data  <= pfx;
        @(posedge clk);
        prefix_reg = pfx;
        cfg_index <= pie_pkg::CFG_NEG_PREFIX;
        cfg_data  <= neg;
        @(posedge clk);
        neg_prefix_reg = neg;
        cfg_we <= 1'b0;
    endtask

    // Random command: mostly fitting slots, some broken or oversized ones
    task automatic random_command();
        logic [7:0]  fc;
        logic [31:0] op;
        logic [31:0] mask;
        int unsigned k;
        int          n;
        int          slot;
        fc   = 8'($urandom_range(0, 255));
        k    = $urandom_range(1, 8);
        mask = (k >= 8) ? 32'hffffffff : ((32'h1 << (4 * k)) - 32'h1);
        case ($urandom_range(0, 5))
            0: op = $urandom;
            1, 2: op = $urandom & mask;
            3, 4: op = ~($urandom & mask) + 32'h1;
            default: op = $urandom_range(0, 1) ? (32'h7fffffff - $urandom_range(0, 255))
                                               : (32'h80000000 + $urandom_range(0, 255));
        endcase
        n = build_encoding_rev(fc, op);
        case ($urandom_range(0, 9))
            0: slot = $urandom_range(0, 31);
            1: slot = n - 1;
            default: slot = n + $urandom_range(0, 3);
        endcase
        if (slot > SLOT_LIMIT && $urandom_range(0, 3) != 0)
            slot = SLOT_LIMIT;
        send_cmd(fc, op, slot[4:0]);
    endtask

    // Edge operands, slot extremes and error cases at reset register values
    task automatic test_directed_cases();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_cmd(8'h40, 32'd0, 5'd1);
        send_cmd(8'h40, 32'd1, 5'd1);
        send_cmd(8'hff, 32'd15, 5'd1);
        send_cmd(8'h00, 32'd16, 5'd2);
        send_cmd(8'h4a, 32'hffffffff, 5'd2);
        send_cmd(8'h4a, 32'hffffffff, 5'd1);
        send_cmd(8'h10, 32'hfffffff0, 5'd2);
        send_cmd(8'h10, 32'hffffffef, 5'd3);
        send_cmd(8'h20, 32'h7fffffff, 5'd8);
        send_cmd(8'h20, 32'h80000000, 5'd8);
        send_cmd(8'h30, 32'h80000000, 5'd7);
        send_cmd(8'h3f, 32'h12345678, 5'd16);
        send_cmd(8'h55, 32'd5, 5'd0);
        send_cmd(8'h55, 32'd5, 5'd17);
        send_cmd(8'h55, 32'd5, 5'd31);
        send_cmd(8'hc0, 32'd256, 5'd2);
        send_cmd(8'hc0, 32'd256, 5'd3);
        send_cmd(8'h0f, 32'd255, 5'd4);
        send_cmd(8'hf0, 32'hffffff00, 5'd5);
        send_cmd(8'haa, 32'h0000ffff, 5'd16);
        send_cmd(8'h01, 32'hfffffff0, 5'd16);
        wait_idle();
    endtask

    // Register extremes: all-zero and all-one opcodes both ways round
    task automatic test_register_extremes();
        set_registers(8'h00, 8'hff);
        send_cmd(8'h0f, 32'h9abcdef0, 5'd8);
        send_cmd(8'hf5, 32'h80000001, 5'd10);
        send_cmd(8'h00, 32'h00000123, 5'd6);
        send_cmd(8'hff, 32'hfffffedc, 5'd4);
        send_cmd(8'h3c, 32'h0000000a, 5'd3);
        wait_idle();
        set_registers(8'hff, 8'h00);
        send_cmd(8'h00, 32'h76543210, 5'd9);
        send_cmd(8'h5a, 32'h8000ffff, 5'd8);
        send_cmd(8'ha5, 32'h00000042, 5'd2);
        send_cmd(8'h0f, 32'hffff1234, 5'd16);
        send_cmd(8'h77, 32'hffffffff, 5'd0);
        wait_idle();
    endtask

    // Random traffic under several register settings
    task automatic test_random_traffic();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
                set_registers(pie_pkg::PREFIX_RESET, pie_pkg::NEG_PREFIX_RESET);
            else
                set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            for (int i = 0; i < 25; i++)
                random_command();
            wait_idle();
        end
    endtask

    // Neither side idles
    task automatic test_back_to_back();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        for (int i = 0; i < 15; i++)
            random_command();
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while commands keep coming
    task automatic test_output_backpressure();
        tx_gaps      = 1'b0;
        rx_stalls    = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 15; i++)
            random_command();
        wait_idle();
    endtask

    // Receiver: random stall before each transfer, long hold on request
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_stalls ? $urandom_range(0, 19) : 0;
            if (hold_request > 0)
            begin
                gap          = hold_request;
                hold_request = 0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    // Result checker: compare each transfer with the oldest expected byte
    always @(posedge clk)
    begin : check_results
        pie_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected result %02h final %0b error %0b",
                                result.code_byte, result.final_byte, result.overflow_error));
            else
            begin
                want = expected_bytes.pop_front();
                if (result.code_byte !== want.code_byte)
                    report_mismatch($sformatf("code_byte got %02h want %02h",
                                    result.code_byte, want.code_byte));
                if (result.final_byte !== want.final_byte)
                    report_mismatch($sformatf("final_byte got %0b want %0b",
                                    result.final_byte, want.final_byte));
                if (result.overflow_error !== want.overflow_error)
                    report_mismatch($sformatf("overflow_error got %0b want %0b",
                                    result.overflow_error, want.overflow_error));
            end
        end
    end

    // Watchdog: too many cycles without any transfer
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        mismatch_count = 0;
        hold_request   = 0;
        tx_gaps        = 1'b1;
        rx_stalls      = 1'b1;
        prefix_reg     = pie_pkg::PREFIX_RESET;
        neg_prefix_reg = pie_pkg::NEG_PREFIX_RESET;
        rst_n     <= 1'b0;
        cmd       <= '0;
        push      <= 1'b0;
        pop       <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= pie_pkg::CFG_PREFIX;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_back_to_back();
        test_output_backpressure();

        wait_idle();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
